@@ rtl/tgarle_pkg.sv @@
// Shared types and constants of the TGA run-length pixel decoder.
package tgarle_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_FOUR_BYTE    = 3'd2;
  localparam logic [2:0] CFG_RLE_MODE     = 3'd3;
  localparam logic [2:0] CFG_TOP_DOWN     = 3'd4;

  localparam logic [15:0] MIN_WIDTH     = 16'd4;
  localparam logic [15:0] RESET_WIDTH   = 16'd4;
  localparam logic [15:0] RESET_HEIGHT  = 16'd1;
  localparam logic [7:0]  ALPHA_OPAQUE  = 8'hFF;
  localparam logic [1:0]  LAST_SLOT_BGR  = 2'd2;
  localparam logic [1:0]  LAST_SLOT_BGRA = 2'd3;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_PLACE
  } ctrl_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;    // take the input word this cycle
    logic emit;      // write the next segment to the output register
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic ovr_now;   // input word falls past the image end
    logic pix_now;   // input word completes a pixel
    logic seg_last;  // current segment finishes the run
  } dp_sts_t;

  typedef struct packed {
    logic [15:0] x_start;
    logic [15:0] tex_row;
    logic [7:0]  seg_count;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        image_done;
    logic        overrun;
    logic        last_of_item;
  } seg_t;

endpackage

@@ rtl/tgarle_ctrl.sv @@
// Controller: byte acceptance, segment sequencing and output word valid.
module tgarle_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output tgarle_pkg::dp_cmd_t cmd,
  input  tgarle_pkg::dp_sts_t sts
);

  tgarle_pkg::ctrl_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_busy;
  logic out_load;

  assign out_busy = out_valid_r && out_stall;

  // Drive handshake and datapath commands
  always_comb begin
    in_stall   = 1'b1;
    cmd.accept = 1'b0;
    cmd.emit   = 1'b0;
    unique case (state_r)
      tgarle_pkg::ST_IDLE: begin
        in_stall   = out_busy;
        cmd.accept = in_valid && !out_busy;
      end
      tgarle_pkg::ST_PLACE: begin
        cmd.emit = !out_busy;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Advance between byte intake and segment output
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tgarle_pkg::ST_IDLE: begin
        if (cmd.accept && sts.pix_now) state_nxt = tgarle_pkg::ST_PLACE;
      end
      tgarle_pkg::ST_PLACE: begin
        if (cmd.emit && sts.seg_last) state_nxt = tgarle_pkg::ST_IDLE;
      end
      default: state_nxt = tgarle_pkg::ST_IDLE;
    endcase
  end

  // Hold the output word until taken
  assign out_load = (cmd.accept && sts.ovr_now) || cmd.emit;

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tgarle_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ rtl/tgarle_dp.sv @@
// Datapath: configuration, packet and pixel gathering, row placement, output word.
module tgarle_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_wdata,
  input  logic [7:0]          in_data_byte,
  input  logic                in_image_start,
  input  tgarle_pkg::dp_cmd_t cmd,
  output tgarle_pkg::dp_sts_t sts,
  output tgarle_pkg::seg_t    seg
);

  // Configuration registers
  logic [15:0] width_r, height_r;
  logic        four_r, rle_r, top_down_r;

  // Decoder state
  logic        exp_hdr_r, exp_hdr_nxt;
  logic        rep_r, rep_nxt;
  logic [7:0]  pleft_r, pleft_nxt;
  logic [1:0]  slot_r, slot_nxt;
  logic [23:0] gather_r, gather_nxt;
  logic [15:0] col_r, col_nxt;
  logic [15:0] rows_r, rows_nxt;

  // Pending run
  logic [7:0]  run_n_r, run_n_nxt;
  logic [7:0]  run_red_r, run_red_nxt;
  logic [7:0]  run_green_r, run_green_nxt;
  logic [7:0]  run_blue_r, run_blue_nxt;
  logic [7:0]  run_alpha_r, run_alpha_nxt;

  tgarle_pkg::seg_t seg_r, seg_nxt;

  // Intake view of the state, after an image restart
  logic        exp_hdr_c, rep_c;
  logic [7:0]  pleft_c;
  logic [1:0]  slot_c;
  logic [23:0] gather_c;
  logic [15:0] col_c, rows_c;
  logic        hdr_now;
  logic [1:0]  last_slot;
  logic [7:0]  pix_red, pix_alpha;

  // Placement of one segment
  logic [15:0] w_eff, col_e, rows_e, room, rows_inc, tex_row;
  logic        wrap, full, row_end, done;
  logic [7:0]  take, n_left;
  logic [16:0] col_sum;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= tgarle_pkg::RESET_WIDTH;
      height_r   <= tgarle_pkg::RESET_HEIGHT;
      four_r     <= 1'b0;
      rle_r      <= 1'b0;
      top_down_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tgarle_pkg::CFG_IMAGE_WIDTH:  width_r    <= cfg_wdata;
        tgarle_pkg::CFG_IMAGE_HEIGHT: height_r   <= cfg_wdata;
        tgarle_pkg::CFG_FOUR_BYTE:    four_r     <= cfg_wdata[0];
        tgarle_pkg::CFG_RLE_MODE:     rle_r      <= cfg_wdata[0];
        tgarle_pkg::CFG_TOP_DOWN:     top_down_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Clear decoder state on image start
  assign exp_hdr_c = in_image_start ? 1'b1  : exp_hdr_r;
  assign rep_c     = in_image_start ? 1'b0  : rep_r;
  assign pleft_c   = in_image_start ? 8'd0  : pleft_r;
  assign slot_c    = in_image_start ? 2'd0  : slot_r;
  assign gather_c  = in_image_start ? 24'd0 : gather_r;
  assign col_c     = in_image_start ? 16'd0 : col_r;
  assign rows_c    = in_image_start ? 16'd0 : rows_r;

  // Classify the input byte
  assign last_slot   = four_r ? tgarle_pkg::LAST_SLOT_BGRA : tgarle_pkg::LAST_SLOT_BGR;
  assign sts.ovr_now = rows_c >= height_r;
  assign hdr_now     = rle_r && exp_hdr_c;
  assign sts.pix_now = !sts.ovr_now && !hdr_now && (slot_c >= last_slot);
  assign pix_red     = four_r ? gather_c[23:16] : in_data_byte;
  assign pix_alpha   = four_r ? in_data_byte : tgarle_pkg::ALPHA_OPAQUE;

  // Split the run at the row edge
  assign w_eff    = (width_r < tgarle_pkg::MIN_WIDTH) ? tgarle_pkg::MIN_WIDTH : width_r;
  assign wrap     = col_r >= w_eff;
  assign col_e    = wrap ? 16'd0 : col_r;
  assign rows_e   = (wrap && (rows_r < height_r)) ? rows_r + 16'd1 : rows_r;
  assign full     = rows_e >= height_r;
  assign room     = w_eff - col_e;
  assign take     = ({8'd0, run_n_r} < room) ? run_n_r : room[7:0];
  assign col_sum  = {1'b0, col_e} + {9'd0, take};
  assign row_end  = col_sum == {1'b0, w_eff};
  assign rows_inc = rows_e + 16'd1;
  assign done     = row_end && (rows_inc >= height_r);
  assign tex_row  = top_down_r ? rows_e : height_r - 16'd1 - rows_e;
  assign n_left   = run_n_r - take;
  assign sts.seg_last = full || (n_left == 8'd0);

  // Next decoder and run state
  always_comb begin
    exp_hdr_nxt   = exp_hdr_r;
    rep_nxt       = rep_r;
    pleft_nxt     = pleft_r;
    slot_nxt      = slot_r;
    gather_nxt    = gather_r;
    col_nxt       = col_r;
    rows_nxt      = rows_r;
    run_n_nxt     = run_n_r;
    run_red_nxt   = run_red_r;
    run_green_nxt = run_green_r;
    run_blue_nxt  = run_blue_r;
    run_alpha_nxt = run_alpha_r;
    if (cmd.accept) begin
      exp_hdr_nxt = exp_hdr_c;
      rep_nxt     = rep_c;
      pleft_nxt   = pleft_c;
      slot_nxt    = slot_c;
      gather_nxt  = gather_c;
      col_nxt     = col_c;
      rows_nxt    = rows_c;
      if (!sts.ovr_now) begin
        if (hdr_now) begin
          // Packet header: repeat flag and count
          exp_hdr_nxt = 1'b0;
          rep_nxt     = in_data_byte[7];
          pleft_nxt   = {1'b0, in_data_byte[6:0]} + 8'd1;
          slot_nxt    = 2'd0;
          gather_nxt  = 24'd0;
        end else if (!sts.pix_now) begin
          // Gather one colour byte
          case (slot_c)
            2'd0:    gather_nxt[7:0]   = in_data_byte;
            2'd1:    gather_nxt[15:8]  = in_data_byte;
            2'd2:    gather_nxt[23:16] = in_data_byte;
            default: gather_nxt        = gather_c;
          endcase
          slot_nxt = slot_c + 2'd1;
        end else begin
          // Pixel complete: latch the run
          slot_nxt      = 2'd0;
          gather_nxt    = 24'd0;
          run_red_nxt   = pix_red;
          run_green_nxt = gather_c[15:8];
          run_blue_nxt  = gather_c[7:0];
          run_alpha_nxt = pix_alpha;
          run_n_nxt     = 8'd1;
          if (rle_r) begin
            if (rep_c) begin
              run_n_nxt   = (pleft_c == 8'd0) ? 8'd1 : pleft_c;
              pleft_nxt   = 8'd0;
              exp_hdr_nxt = 1'b1;
            end else begin
              if (pleft_c != 8'd0) pleft_nxt = pleft_c - 8'd1;
              if (pleft_c <= 8'd1) exp_hdr_nxt = 1'b1;
            end
          end
        end
      end
    end else if (cmd.emit) begin
      // Advance the row position past this segment
      col_nxt  = col_e;
      rows_nxt = rows_e;
      if (!full) begin
        col_nxt   = row_end ? 16'd0 : col_sum[15:0];
        rows_nxt  = row_end ? rows_inc : rows_e;
        run_n_nxt = n_left;
      end
    end
  end

  // Load the output word
  always_comb begin
    seg_nxt = seg_r;
    if (cmd.accept && sts.ovr_now) begin
      seg_nxt              = '0;
      seg_nxt.seg_count    = 8'd1;
      seg_nxt.overrun      = 1'b1;
      seg_nxt.last_of_item = 1'b1;
    end else if (cmd.emit) begin
      seg_nxt.red   = run_red_r;
      seg_nxt.green = run_green_r;
      seg_nxt.blue  = run_blue_r;
      seg_nxt.alpha = run_alpha_r;
      if (full) begin
        seg_nxt.x_start      = 16'd0;
        seg_nxt.tex_row      = 16'd0;
        seg_nxt.seg_count    = run_n_r;
        seg_nxt.image_done   = 1'b0;
        seg_nxt.overrun      = 1'b1;
        seg_nxt.last_of_item = 1'b1;
      end else begin
        seg_nxt.x_start      = col_e;
        seg_nxt.tex_row      = tex_row;
        seg_nxt.seg_count    = take;
        seg_nxt.image_done   = done;
        seg_nxt.overrun      = 1'b0;
        seg_nxt.last_of_item = sts.seg_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_hdr_r <= 1'b1;
      rep_r     <= 1'b0;
      pleft_r   <= 8'd0;
      slot_r    <= 2'd0;
      gather_r  <= 24'd0;
      col_r     <= 16'd0;
      rows_r    <= 16'd0;
    end else begin
      exp_hdr_r <= exp_hdr_nxt;
      rep_r     <= rep_nxt;
      pleft_r   <= pleft_nxt;
      slot_r    <= slot_nxt;
      gather_r  <= gather_nxt;
      col_r     <= col_nxt;
      rows_r    <= rows_nxt;
    end
  end

  // Run and output payload
  always_ff @(posedge clk) begin
    run_n_r     <= run_n_nxt;
    run_red_r   <= run_red_nxt;
    run_green_r <= run_green_nxt;
    run_blue_r  <= run_blue_nxt;
    run_alpha_r <= run_alpha_nxt;
    seg_r       <= seg_nxt;
  end

  assign seg = seg_r;

endmodule

@@ rtl/tga_rle_pixel_decoder.sv @@
// A header or colour byte goes into the decoder registers; a byte past the image end
// shows its overrun word the next cycle; a pixel-completing byte is latched into the run
// registers, then its first segment enters the output register once that is not blocked.
// Throughput, when the output is free: 1 byte per cycle for header and colour bytes; a
// pixel-completing byte stalls input while the sequencer writes one row segment per cycle.
// Reset (rst_n low, synchronous): decoder cleared, width 4, height 1, other config bits 0.
module tga_rle_pixel_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_image_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_x_start,
  output logic [15:0] out_tex_row,
  output logic [7:0]  out_seg_count,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  output logic        out_image_done,
  output logic        out_overrun,
  output logic        out_last_of_item
);

  tgarle_pkg::dp_cmd_t cmd;
  tgarle_pkg::dp_sts_t sts;
  tgarle_pkg::seg_t    seg;

  // Registers accept a word every cycle
  assign cfg_ready = 1'b1;

  tgarle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  tgarle_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_data_byte   (in_data_byte),
    .in_image_start (in_image_start),
    .cmd            (cmd),
    .sts            (sts),
    .seg            (seg)
  );

  // Unpack the output word
  assign out_x_start      = seg.x_start;
  assign out_tex_row      = seg.tex_row;
  assign out_seg_count    = seg.seg_count;
  assign out_red          = seg.red;
  assign out_green        = seg.green;
  assign out_blue         = seg.blue;
  assign out_alpha        = seg.alpha;
  assign out_image_done   = seg.image_done;
  assign out_overrun      = seg.overrun;
  assign out_last_of_item = seg.last_of_item;

`ifndef ASSERT_OFF
  // No byte taken while a finished word is stuck at the output
  a_no_accept_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !(out_valid && out_stall))
    else $error("byte accepted while output word blocked");

  // A dropped byte yields a single overrun word next cycle
  a_overrun_word: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && sts.ovr_now) |=> (out_valid && out_overrun && out_last_of_item))
    else $error("dropped byte did not produce overrun word");

  // Every delivered word carries at least one pixel
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_seg_count != 8'd0))
    else $error("segment with zero count");

  // The closing segment of an image is never an overrun
  a_done_not_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_image_done) |-> !out_overrun)
    else $error("image_done set on overrun word");
`endif

endmodule

@@ tb/tgarle_checker.sv @@
`timescale 1ns / 100ps
// Checker for the TGA run-length pixel decoder: watches all channels, predicts and compares.
module tgarle_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_image_start,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] out_x_start,
  input  logic [15:0] out_tex_row,
  input  logic [7:0]  out_seg_count,
  input  logic [7:0]  out_red,
  input  logic [7:0]  out_green,
  input  logic [7:0]  out_blue,
  input  logic [7:0]  out_alpha,
  input  logic        out_image_done,
  input  logic        out_overrun,
  input  logic        out_last_of_item,
  output int unsigned fail_count,
  output int unsigned pending_words
);

  // Register copies
  logic [15:0] reg_width;
  logic [15:0] reg_height;
  logic        reg_four_byte;
  logic        reg_rle;
  logic        reg_top_down;

  // Decoder state
  logic        awaiting_header;
  logic        run_is_repeat;
  logic [7:0]  run_left;
  logic [1:0]  slot;
  logic [23:0] gather;
  logic [15:0] col;
  logic [16:0] rows_filled;

  tgarle_pkg::seg_t due_segments[$];
  int unsigned      words_this_byte;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (fail_count < 100)
      $display("%0t: %s got %0h, want %0h", $time, what, got, want);
    fail_count++;
  endtask

  task automatic compare_field(input string what, input int unsigned got,
                               input int unsigned want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  task automatic clear_decoder();
    awaiting_header = 1'b1;
    run_is_repeat = 1'b0;
    run_left = '0;
    slot = '0;
    gather = '0;
    col = '0;
    rows_filled = '0;
  endtask

  task automatic push_segment(input int unsigned x, input int unsigned row,
                              input int unsigned cnt, input logic [7:0] r,
                              input logic [7:0] g, input logic [7:0] b,
                              input logic [7:0] a, input logic done, input logic ovr);
    tgarle_pkg::seg_t s;
    s.x_start = x[15:0];
    s.tex_row = row[15:0];
    s.seg_count = cnt[7:0];
    s.red = r;
    s.green = g;
    s.blue = b;
    s.alpha = a;
    s.image_done = done;
    s.overrun = ovr;
    s.last_of_item = 1'b0;
    due_segments.push_back(s);
    words_this_byte++;
  endtask

  // Split a run of equal pixels into row segments, drop what falls past the image end
  task automatic place_run(input int unsigned count, input logic [7:0] r,
                           input logic [7:0] g, input logic [7:0] b, input logic [7:0] a);
    int unsigned w, room, take, row, x;
    logic done;
    w = 32'((reg_width < tgarle_pkg::MIN_WIDTH) ? tgarle_pkg::MIN_WIDTH : reg_width);
    while (count > 0) begin
      if (col >= w) begin
        col = '0;
        if (rows_filled < reg_height) rows_filled++;
      end
      if (rows_filled >= reg_height) begin
        push_segment(0, 0, count, r, g, b, a, 1'b0, 1'b1);
        count = 0;
      end else begin
        room = w - col;
        take = (count < room) ? count : room;
        row = reg_top_down ? 32'(rows_filled) : (32'(reg_height) - 1 - 32'(rows_filled));
        x = 32'(col);
        done = 1'b0;
        col = 16'(col + take);
        if (col == w) begin
          col = '0;
          rows_filled++;
          if (rows_filled >= reg_height) done = 1'b1;
        end
        push_segment(x, row, take, r, g, b, a, done, 1'b0);
        count = count - take;
      end
    end
  endtask

  // Work out the segments that one accepted byte causes
  task automatic decode_byte(input logic [7:0] data, input logic start);
    logic [1:0] last_slot;
    logic [7:0] r, g, b, a;
    tgarle_pkg::seg_t tail;
    words_this_byte = 0;
    if (start) clear_decoder();
    if (rows_filled >= reg_height) begin
      push_segment(0, 0, 1, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1);
    end else if (reg_rle && awaiting_header) begin
      awaiting_header = 1'b0;
      run_is_repeat = data[7];
      run_left = {1'b0, data[6:0]} + 8'd1;
      slot = '0;
      gather = '0;
    end else begin
      last_slot = reg_four_byte ? tgarle_pkg::LAST_SLOT_BGRA : tgarle_pkg::LAST_SLOT_BGR;
      if (slot < last_slot) begin
        gather = gather | ({16'd0, data} << (8 * slot));
        slot = slot + 2'd1;
      end else begin
        b = gather[7:0];
        g = gather[15:8];
        if (reg_four_byte) begin
          r = gather[23:16];
          a = data;
        end else begin
          r = data;
          a = tgarle_pkg::ALPHA_OPAQUE;
        end
        slot = '0;
        gather = '0;
        if (!reg_rle) begin
          place_run(1, r, g, b, a);
        end else if (run_is_repeat) begin
          place_run((run_left == 0) ? 1 : 32'(run_left), r, g, b, a);
          run_left = '0;
          awaiting_header = 1'b1;
        end else begin
          place_run(1, r, g, b, a);
          if (run_left > 0) run_left--;
          if (run_left == 0) awaiting_header = 1'b1;
        end
      end
    end
    // mark the last word of this byte
    if (words_this_byte > 0) begin
      tail = due_segments.pop_back();
      tail.last_of_item = 1'b1;
      due_segments.push_back(tail);
    end
  endtask

  task automatic check_word();
    tgarle_pkg::seg_t want;
    if (due_segments.size() == 0) begin
      report_mismatch("word with none due, x_start", 32'(out_x_start), 0);
    end else begin
      want = due_segments.pop_front();
      compare_field("x_start", 32'(out_x_start), 32'(want.x_start));
      compare_field("tex_row", 32'(out_tex_row), 32'(want.tex_row));
      compare_field("seg_count", 32'(out_seg_count), 32'(want.seg_count));
      compare_field("red", 32'(out_red), 32'(want.red));
      compare_field("green", 32'(out_green), 32'(want.green));
      compare_field("blue", 32'(out_blue), 32'(want.blue));
      compare_field("alpha", 32'(out_alpha), 32'(want.alpha));
      compare_field("image_done", 32'(out_image_done), 32'(want.image_done));
      compare_field("overrun", 32'(out_overrun), 32'(want.overrun));
      compare_field("last_of_item", 32'(out_last_of_item), 32'(want.last_of_item));
    end
  endtask

  // Track registers, predict on each input word, compare each output word
  always @(posedge clk) begin
    if (!rst_n) begin
      reg_width = tgarle_pkg::RESET_WIDTH;
      reg_height = tgarle_pkg::RESET_HEIGHT;
      reg_four_byte = 1'b0;
      reg_rle = 1'b0;
      reg_top_down = 1'b0;
      clear_decoder();
      due_segments.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tgarle_pkg::CFG_IMAGE_WIDTH:  reg_width = cfg_wdata;
          tgarle_pkg::CFG_IMAGE_HEIGHT: reg_height = cfg_wdata;
          tgarle_pkg::CFG_FOUR_BYTE:    reg_four_byte = cfg_wdata[0];
          tgarle_pkg::CFG_RLE_MODE:     reg_rle = cfg_wdata[0];
          tgarle_pkg::CFG_TOP_DOWN:     reg_top_down = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) decode_byte(in_data_byte, in_image_start);
      if (out_valid && !out_stall) check_word();
    end
    pending_words = due_segments.size();
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Top of the decoder testbench: clock, reset, stimulus, back-pressure and verdict.
module testbench;

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_image_start;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_x_start;
  logic [15:0] out_tex_row;
  logic [7:0]  out_seg_count;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [7:0]  out_alpha;
  logic        out_image_done;
  logic        out_overrun;
  logic        out_last_of_item;

  int unsigned fail_count;
  int unsigned pending_words;
  int unsigned cycle_count = 0;
  logic        no_gaps = 1'b0;
  logic        fmt_four_byte = 1'b0;
  logic        fmt_rle = 1'b0;

  tga_rle_pixel_decoder u_dut (.*);

  tgarle_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tga_rle_pixel_decoder verification failed");
      $finish;
    end
  end

  // Output back-pressure: draw a hold before each word
  initial begin : stall_gen
    int unsigned hold;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      hold = no_gaps ? 0 : $urandom_range(0, 13);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  // Offer one byte after a random gap and hold it until taken
  task automatic send_byte(input logic [7:0] data, input logic start);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= data;
    in_image_start <= start;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input logic [15:0] width, input logic [15:0] height,
                           input logic four_byte, input logic rle, input logic top_down);
    write_reg(tgarle_pkg::CFG_IMAGE_WIDTH, width);
    write_reg(tgarle_pkg::CFG_IMAGE_HEIGHT, height);
    write_reg(tgarle_pkg::CFG_FOUR_BYTE, {15'd0, four_byte});
    write_reg(tgarle_pkg::CFG_RLE_MODE, {15'd0, rle});
    write_reg(tgarle_pkg::CFG_TOP_DOWN, {15'd0, top_down});
    cfg_valid <= 1'b0;
    fmt_four_byte = four_byte;
    fmt_rle = rle;
  endtask

  // Hold the stream until every due word has come, then let the block go idle
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
    repeat (4) @(posedge clk);
  endtask

  // Mostly well-formed packets with random content, with the odd stray byte
  task automatic random_image(input int unsigned n_bytes);
    int unsigned sent, npix, cnt, bpp;
    logic rep, first;
    sent = 0;
    first = 1'b1;
    bpp = fmt_four_byte ? 4 : 3;
    while (sent < n_bytes) begin
      if ($urandom_range(0, 11) == 0) begin
        send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        npix = 1;
        if (fmt_rle) begin
          rep = 1'($urandom_range(0, 1));
          if (rep)
            cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 6);
          else
            cnt = $urandom_range(0, 3);
          send_byte({rep, cnt[6:0]}, first);
          first = 1'b0;
          sent++;
          npix = rep ? 1 : cnt + 1;
        end
        repeat (npix * bpp) begin
          send_byte(8'($urandom_range(0, 255)), first);
          first = 1'b0;
          sent++;
        end
      end
    end
  endtask

  initial begin : stimulus
    int unsigned w;
    rst_n <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= tgarle_pkg::CFG_IMAGE_WIDTH;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_data_byte <= '0;
    in_image_start <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // raw 24-bit pixels at the reset settings: black then white
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    settle();

    // narrow width, longest repeat running past the image end, then a stray byte
    configure(16'd0, 16'd2, 1'b1, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h04, 1'b0);
    send_byte(8'h80, 1'b0);
    settle();

    // part of a row, then a literal packet stopped half way through a pixel
    configure(16'd6, 16'd3, 1'b1, 1'b1, 1'b1);
    send_byte(8'h84, 1'b1);
    send_byte(8'hC0, 1'b0);
    send_byte(8'hC1, 1'b0);
    send_byte(8'hC2, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h10, 1'b0);
    send_byte(8'h20, 1'b0);
    settle();

    // shrink the width under the column and drop to 24-bit pixels mid-pixel
    configure(16'd4, 16'd3, 1'b0, 1'b1, 1'b1);
    send_byte(8'h77, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h66, 1'b0);
    send_byte(8'hAA, 1'b0);
    settle();

    // zero height: every byte is dropped
    configure(16'($urandom_range(4, 7)), 16'd0, 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    random_image(6);

    for (int ph = 0; ph < 5; ph++) begin
      settle();
      no_gaps = (ph == 1) || ($urandom_range(0, 3) == 0);
      w = (ph == 0) ? 4 : $urandom_range(4, 9);
      if (ph == 2)
        configure(16'hFFFF, 16'hFFFF, 1'($urandom_range(0, 1)), 1'b1,
                  1'($urandom_range(0, 1)));
      else
        configure(16'(w), 16'($urandom_range(1, 4)), 1'($urandom_range(0, 1)),
                  $urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)));
      random_image(12);
    end

    // drain, then watch for stray words
    settle();
    no_gaps = 1'b0;
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("tga_rle_pixel_decoder verification clean");
    else
      $display("tga_rle_pixel_decoder verification failed");
    $finish;
  end

endmodule
